[sv/rmf_pkg.sv]
// Shared constants and types for the running median filter.
package rmf_pkg;

    localparam int SAMPLE_W        = 18;
    localparam int MEDIAN_W        = 18;
    localparam int WINDOW_SIZE_DEF = 8;
    localparam int SAMPLE_BITS_DEF = 18;

    typedef struct packed {
        logic load;
        logic shift;
    } ctrl_t;

endpackage

[sv/rmf_if.sv]
// Valid/ready channel interfaces for sample and median transfers.
interface rmf_sample_if;
    logic                           valid;
    logic                           ready;
    logic [rmf_pkg::SAMPLE_W-1:0]   sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface rmf_median_if;
    logic                           valid;
    logic                           ready;
    logic [rmf_pkg::MEDIAN_W-1:0]   median_out;

    modport source (output valid, output median_out, input ready);
    modport sink   (input valid, input median_out, output ready);
endinterface

[sv/rmf_window.sv]
// Circular sample window held as rotating shift registers, MSB presented first.
module rmf_window #(
    parameter int WINDOW_SIZE = rmf_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF,
    parameter int POS_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1
) (
    input  logic                    clk,
    input  rmf_pkg::ctrl_t          ctrl,
    input  logic [POS_W-1:0]        load_pos,
    input  logic [SAMPLE_BITS-1:0]  load_data,
    output logic [WINDOW_SIZE-1:0]  msb
);

    logic [SAMPLE_BITS-1:0] entry_reg [WINDOW_SIZE];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            if (ctrl.load && load_pos == POS_W'(i))
            begin
                entry_reg[i] <= load_data;
            end
            else if (ctrl.shift)
            begin
                entry_reg[i] <= {entry_reg[i][SAMPLE_BITS-2:0], entry_reg[i][SAMPLE_BITS-1]};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            msb[i] = entry_reg[i][SAMPLE_BITS-1];
        end
    end

endmodule

[sv/rmf_select.sv]
// Bit-serial MSB-first rank selection of the two middle order statistics.
module rmf_select #(
    parameter int WINDOW_SIZE = rmf_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(WINDOW_SIZE + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rmf_pkg::ctrl_t          ctrl,
    input  logic [WINDOW_SIZE-1:0]  active_init,
    input  logic [CNT_W-1:0]        k_lo_init,
    input  logic [CNT_W-1:0]        k_hi_init,
    input  logic [WINDOW_SIZE-1:0]  msb,
    output logic [SAMPLE_BITS-1:0]  median
);

    logic [WINDOW_SIZE-1:0] act_lo_reg, act_lo_next;
    logic [WINDOW_SIZE-1:0] act_hi_reg, act_hi_next;
    logic [CNT_W-1:0]       k_lo_reg, k_lo_next;
    logic [CNT_W-1:0]       k_hi_reg, k_hi_next;
    logic [SAMPLE_BITS-1:0] res_lo_reg, res_lo_next;
    logic [SAMPLE_BITS-1:0] res_hi_reg, res_hi_next;
    logic [CNT_W-1:0]       zeros_lo, zeros_hi;
    logic                   bit_lo, bit_hi;
    logic [SAMPLE_BITS:0]   sum;

    // count of active candidates whose current bit is zero
    always_comb
    begin
        zeros_lo = '0;
        zeros_hi = '0;
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            zeros_lo = zeros_lo + CNT_W'(act_lo_reg[i] & ~msb[i]);
            zeros_hi = zeros_hi + CNT_W'(act_hi_reg[i] & ~msb[i]);
        end
        bit_lo = (k_lo_reg >= zeros_lo);
        bit_hi = (k_hi_reg >= zeros_hi);
    end

    always_comb
    begin
        act_lo_next = act_lo_reg;
        act_hi_next = act_hi_reg;
        k_lo_next   = k_lo_reg;
        k_hi_next   = k_hi_reg;
        res_lo_next = res_lo_reg;
        res_hi_next = res_hi_reg;
        if (ctrl.load)
        begin
            act_lo_next = active_init;
            act_hi_next = active_init;
            k_lo_next   = k_lo_init;
            k_hi_next   = k_hi_init;
        end
        else if (ctrl.shift)
        begin
            act_lo_next = bit_lo ? (act_lo_reg & msb) : (act_lo_reg & ~msb);
            act_hi_next = bit_hi ? (act_hi_reg & msb) : (act_hi_reg & ~msb);
            k_lo_next   = bit_lo ? (k_lo_reg - zeros_lo) : k_lo_reg;
            k_hi_next   = bit_hi ? (k_hi_reg - zeros_hi) : k_hi_reg;
            res_lo_next = {res_lo_reg[SAMPLE_BITS-2:0], bit_lo};
            res_hi_next = {res_hi_reg[SAMPLE_BITS-2:0], bit_hi};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_lo_reg <= '0;
            act_hi_reg <= '0;
            k_lo_reg   <= '0;
            k_hi_reg   <= '0;
        end
        else
        begin
            act_lo_reg <= act_lo_next;
            act_hi_reg <= act_hi_next;
            k_lo_reg   <= k_lo_next;
            k_hi_reg   <= k_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
    end

    // equal ranks for an odd count, so the mean is the value itself
    assign sum    = {1'b0, res_lo_reg} + {1'b0, res_hi_reg};
    assign median = sum[SAMPLE_BITS:1];

endmodule

[sv/running_median_filter.sv]
// Running median filter: one median transfer for every sample transfer, over
// the last WINDOW_SIZE samples (or all samples so far while the window fills).
// Each accepted sample is loaded into the window and the median is found by a
// rank search that walks the window's shift registers one sample bit per cycle,
// MSB first, tracking both middle ranks at once, then registered as the result.
// A new sample is accepted as soon as the search is free, once the previous
// median has entered the output register; a finished median waits in the output
// register until taken, holding the search only if the next result is ready first.
module running_median_filter #(
    parameter int WINDOW_SIZE = rmf_pkg::WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    rmf_sample_if.sink          sample_ch,
    rmf_median_if.source        median_ch
);

    localparam int POS_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int BC_W  = $clog2(SAMPLE_BITS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [BC_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [POS_W-1:0]            write_pos_reg, write_pos_next;
    logic [CNT_W-1:0]            fill_reg, fill_next;
    logic                        out_valid_reg, out_valid_next;
    logic [rmf_pkg::MEDIAN_W-1:0] median_reg, median_next;

    rmf_pkg::ctrl_t              ctrl;
    logic                        accept;
    logic [SAMPLE_BITS-1:0]      load_data;
    logic [WINDOW_SIZE-1:0]      active_init;
    logic [CNT_W-1:0]            fill_inc;
    logic [CNT_W-1:0]            k_lo_init, k_hi_init;
    logic [WINDOW_SIZE-1:0]      msb;
    logic [SAMPLE_BITS-1:0]      median;

    assign sample_ch.ready      = (state_reg == S_IDLE);
    assign accept               = sample_ch.valid && sample_ch.ready;
    assign median_ch.valid      = out_valid_reg;
    assign median_ch.median_out = median_reg;

    always_comb
    begin
        load_data = '0;
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            if (i < rmf_pkg::SAMPLE_W)
            begin
                load_data[i] = sample_ch.sample_in[i];
            end
        end
    end

    assign fill_inc  = (fill_reg == CNT_W'(WINDOW_SIZE)) ? fill_reg : fill_reg + 1'b1;
    assign k_lo_init = (fill_inc - 1'b1) >> 1;
    assign k_hi_init = fill_inc >> 1;

    always_comb
    begin
        for (int i = 0; i < WINDOW_SIZE; i++)
        begin
            active_init[i] = (CNT_W'(i) < fill_inc);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_cnt_next   = bit_cnt_reg;
        write_pos_next = write_pos_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        ctrl.load      = 1'b0;
        ctrl.shift     = 1'b0;

        if (median_ch.valid && median_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load      = 1'b1;
                    fill_next      = fill_inc;
                    write_pos_next = (write_pos_reg == POS_W'(WINDOW_SIZE - 1)) ?
                                     '0 : write_pos_reg + 1'b1;
                    bit_cnt_next   = '0;
                    state_next     = S_RUN;
                end
            end
            S_RUN:
            begin
                ctrl.shift   = 1'b1;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BC_W'(SAMPLE_BITS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_next)
                begin
                    median_next = '0;
                    for (int i = 0; i < rmf_pkg::MEDIAN_W; i++)
                    begin
                        if (i < SAMPLE_BITS)
                        begin
                            median_next[i] = median[i];
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bit_cnt_reg   <= '0;
            write_pos_reg <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            write_pos_reg <= write_pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        median_reg <= median_next;
    end

    rmf_window #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .POS_W       (POS_W)
    ) u_window (
        .clk       (clk),
        .ctrl      (ctrl),
        .load_pos  (write_pos_reg),
        .load_data (load_data),
        .msb       (msb)
    );

    rmf_select #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .active_init (active_init),
        .k_lo_init   (k_lo_init),
        .k_hi_init   (k_hi_init),
        .msb         (msb),
        .median      (median)
    );

endmodule
